[rtl/min_max_stack_encoded_assert.svh]
// Assertion macros for the min/max stack RTL.
// Stand-alone header; no dependencies.
`ifndef MIN_MAX_STACK_ENCODED_ASSERT_SVH
`define MIN_MAX_STACK_ENCODED_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MMS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("min_max_stack_encoded: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define MMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("min_max_stack_encoded: assertion failed");

`endif

[rtl/mms_pkg.sv]
// Shared codes and types for the min/max stack.
// No dependencies.
package mms_pkg;

   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_POP  = 2'd1;
   localparam logic [1:0] OP_PEEK = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // Stack memory control
   typedef struct packed {
      logic wr_en;   // write the spilled top entry
      logic fwd;     // next-below entry is the data being written
   } mms_store_ctrl_type;

endpackage

[rtl/mms_store.sv]
// Entry memory below the top of the stack, with a registered read of the
// entry just below the top. Depends on mms_pkg.
module mms_store #(
   parameter int DEPTH   = 64,
   parameter int ENTRY_W = 18
) (
   input  logic                            clock,
   input  mms_pkg::mms_store_ctrl_type     ctrl,
   input  logic [$clog2(DEPTH)-1:0]        wr_addr,
   input  logic signed [ENTRY_W-1:0]       wr_data,
   input  logic [$clog2(DEPTH)-1:0]        rd_addr,
   output logic signed [ENTRY_W-1:0]       below_entry
);

   logic signed [ENTRY_W-1:0] mem [DEPTH];
   logic signed [ENTRY_W-1:0] below_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // forward the spilled entry, it becomes the one below the new top
   always_ff @(posedge clock) begin
      if (ctrl.fwd) begin
         below_ff <= wr_data;
      end else begin
         below_ff <= mem[rd_addr];
      end
   end

   assign below_entry = below_ff;

endmodule

[rtl/mms_update.sv]
// Next-state and result logic for one stack request.
// Depends on mms_pkg.
module mms_update #(
   parameter int DEPTH = 64,
   parameter int W     = 16
) (
   input  logic [1:0]                          op,
   input  logic signed [W-1:0]                 value,
   input  logic [$clog2(DEPTH+1)-1:0]          count,
   input  logic signed [W+1:0]                 top_entry,
   input  logic signed [W+1:0]                 below_entry,
   input  logic signed [W-1:0]                 run_max,
   input  logic signed [W-1:0]                 run_min,
   output logic [$clog2(DEPTH+1)-1:0]          count_n,
   output logic signed [W+1:0]                 top_n,
   output logic signed [W-1:0]                 max_n,
   output logic signed [W-1:0]                 min_n,
   output mms_pkg::mms_store_ctrl_type         store_ctrl,
   output logic [$clog2(DEPTH)-1:0]            wr_addr,
   output logic [$clog2(DEPTH)-1:0]            rd_addr,
   output logic signed [W-1:0]                 res_top,
   output logic signed [W-1:0]                 res_max,
   output logic signed [W-1:0]                 res_min,
   output logic                                res_empty,
   output logic [1:0]                          res_status
);

   localparam int EW = W + 2;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);

   logic signed [EW-1:0] x_ext;
   logic signed [EW-1:0] max_ext;
   logic signed [EW-1:0] min_ext;
   logic signed [EW-1:0] maxn_ext;
   logic signed [EW-1:0] minn_ext;
   logic signed [EW-1:0] restore;
   logic [CW-1:0]        below_idx;
   logic [CW-1:0]        spill_idx;

   assign x_ext   = {{2{value[W-1]}}, value};
   assign max_ext = {{2{run_max[W-1]}}, run_max};
   assign min_ext = {{2{run_min[W-1]}}, run_min};

   always_comb begin
      count_n    = count;
      top_n      = top_entry;
      max_n      = run_max;
      min_n      = run_min;
      store_ctrl = '0;
      res_status = mms_pkg::ST_OK;
      restore    = '0;
      case (op)
         mms_pkg::OP_PUSH: begin
            if (count == CW'(DEPTH)) begin
               res_status = mms_pkg::ST_FULL;
            end else begin
               count_n          = count + CW'(1);
               store_ctrl.wr_en = (count != '0);
               store_ctrl.fwd   = (count != '0);
               if (count == '0) begin
                  top_n = x_ext;
                  max_n = value;
                  min_n = value;
               end else if (x_ext > max_ext) begin
                  top_n = (x_ext <<< 1) - max_ext;
                  max_n = value;
               end else if (x_ext < min_ext) begin
                  top_n = (x_ext <<< 1) - min_ext;
                  min_n = value;
               end else begin
                  top_n = x_ext;
               end
            end
         end
         mms_pkg::OP_POP: begin
            if (count == '0) begin
               res_status = mms_pkg::ST_EMPTY;
            end else begin
               count_n = count - CW'(1);
               top_n   = below_entry;
               if (top_entry > max_ext) begin
                  restore = (max_ext <<< 1) - top_entry;
                  max_n   = restore[W-1:0];
               end else if (top_entry < min_ext) begin
                  restore = (min_ext <<< 1) - top_entry;
                  min_n   = restore[W-1:0];
               end
            end
         end
         default: begin
            // peek and the unused code leave the stack alone
         end
      endcase
   end

   assign spill_idx = count - CW'(1);
   assign below_idx = count_n - CW'(2);
   assign wr_addr   = spill_idx[AW-1:0];
   assign rd_addr   = below_idx[AW-1:0];

   assign maxn_ext = {{2{max_n[W-1]}}, max_n};
   assign minn_ext = {{2{min_n[W-1]}}, min_n};

   always_comb begin
      res_empty = (count_n == '0);
      res_top   = '0;
      res_max   = '0;
      res_min   = '0;
      if (!res_empty) begin
         res_max = max_n;
         res_min = min_n;
         if (top_n > maxn_ext) begin
            res_top = max_n;
         end else if (top_n < minn_ext) begin
            res_top = min_n;
         end else begin
            res_top = top_n[W-1:0];
         end
      end
   end

endmodule

[rtl/min_max_stack_encoded.sv]
// Min/max stack, top level: a LIFO of signed values that reports its top
// element, its maximum and its minimum after every request. Takes one
// request per clock cycle while rsp_stall is low; each request passes
// through an input register and a result register before it is answered,
// and the whole update touches only the top-entry register, the running
// max/min registers and one memory port. Operation codes: push, pop, peek
// (the fourth code acts as peek). Push onto a full stack and pop from an
// empty one change nothing and report a status code; an empty stack reports
// zero top/max/min. No clearing pass is needed after reset. Depends on
// mms_pkg, mms_store, mms_update and min_max_stack_encoded_assert.svh.
module min_max_stack_encoded #(
   parameter int STACK_DEPTH = 64,
   parameter int VALUE_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_operation,
   input  logic signed [VALUE_WIDTH-1:0]         req_value,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [VALUE_WIDTH-1:0]         rsp_top_value,
   output logic signed [VALUE_WIDTH-1:0]         rsp_max_value,
   output logic signed [VALUE_WIDTH-1:0]         rsp_min_value,
   output logic                                  rsp_is_empty,
   output logic [$clog2(STACK_DEPTH+1)-1:0]      rsp_fill_count,
   output logic [1:0]                            rsp_status
);

`include "min_max_stack_encoded_assert.svh"

   localparam int EW = VALUE_WIDTH + 2;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   // Input register
   logic                          in_valid_ff;
   logic [1:0]                    in_op_ff;
   logic signed [VALUE_WIDTH-1:0] in_value_ff;

   // Stack state: the top entry is held in a register, the rest in memory
   logic [CW-1:0]                 count_ff;
   logic signed [EW-1:0]          top_ff;
   logic signed [VALUE_WIDTH-1:0] max_ff;
   logic signed [VALUE_WIDTH-1:0] min_ff;

   // Result register
   logic                          rsp_valid_ff;
   logic signed [VALUE_WIDTH-1:0] rsp_top_ff;
   logic signed [VALUE_WIDTH-1:0] rsp_max_ff;
   logic signed [VALUE_WIDTH-1:0] rsp_min_ff;
   logic                          rsp_empty_ff;
   logic [CW-1:0]                 rsp_count_ff;
   logic [1:0]                    rsp_status_ff;

   // Update outputs
   logic                          rsp_load;
   logic                          fire;
   logic [1:0]                    eff_op;
   logic [CW-1:0]                 count_in;
   logic signed [EW-1:0]          top_in;
   logic signed [VALUE_WIDTH-1:0] max_in;
   logic signed [VALUE_WIDTH-1:0] min_in;
   mms_pkg::mms_store_ctrl_type   store_ctrl;
   logic [AW-1:0]                 wr_addr;
   logic [AW-1:0]                 rd_addr;
   logic signed [EW-1:0]          below_entry;
   logic signed [VALUE_WIDTH-1:0] res_top;
   logic signed [VALUE_WIDTH-1:0] res_max;
   logic signed [VALUE_WIDTH-1:0] res_min;
   logic                          res_empty;
   logic [1:0]                    res_status;

   // The result register can take a new result when it is empty or draining.
   assign rsp_load  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && rsp_load;
   assign req_stall = in_valid_ff && !rsp_load;

   // Without a request in flight, run the update as a peek so that the
   // memory keeps prefetching the entry below the top and nothing is written.
   assign eff_op = fire ? in_op_ff : mms_pkg::OP_PEEK;

   // Capture a request whenever the input register is free or advancing.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_op_ff    <= req_operation;
         in_value_ff <= req_value;
      end
   end

   mms_update #(
      .DEPTH (STACK_DEPTH),
      .W     (VALUE_WIDTH)
   ) u_update (
      .op          (eff_op),
      .value       (in_value_ff),
      .count       (count_ff),
      .top_entry   (top_ff),
      .below_entry (below_entry),
      .run_max     (max_ff),
      .run_min     (min_ff),
      .count_n     (count_in),
      .top_n       (top_in),
      .max_n       (max_in),
      .min_n       (min_in),
      .store_ctrl  (store_ctrl),
      .wr_addr     (wr_addr),
      .rd_addr     (rd_addr),
      .res_top     (res_top),
      .res_max     (res_max),
      .res_min     (res_min),
      .res_empty   (res_empty),
      .res_status  (res_status)
   );

   // A push spills the old top into memory; the memory also registers the
   // entry below the new top so that a pop in the next cycle finds it ready.
   mms_store #(
      .DEPTH   (STACK_DEPTH),
      .ENTRY_W (EW)
   ) u_store (
      .clock       (clock),
      .ctrl        (store_ctrl),
      .wr_addr     (wr_addr),
      .wr_data     (top_ff),
      .rd_addr     (rd_addr),
      .below_entry (below_entry)
   );

   // Advance the stack state; peeks leave it unchanged.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         max_ff   <= '0;
         min_ff   <= '0;
      end else begin
         count_ff <= count_in;
         max_ff   <= max_in;
         min_ff   <= min_in;
      end
   end

   // The top entry is only read while the stack holds something.
   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

   // Hold the result until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_top_ff    <= res_top;
         rsp_max_ff    <= res_max;
         rsp_min_ff    <= res_min;
         rsp_empty_ff  <= res_empty;
         rsp_count_ff  <= count_in;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_top_value  = rsp_top_ff;
   assign rsp_max_value  = rsp_max_ff;
   assign rsp_min_value  = rsp_min_ff;
   assign rsp_is_empty   = rsp_empty_ff;
   assign rsp_fill_count = rsp_count_ff;
   assign rsp_status     = rsp_status_ff;

   // Fill level never passes the stack depth
   `MMS_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(STACK_DEPTH))
   // A non-empty stack keeps its maximum at or above its minimum
   `MMS_ASSERT_IMPL(a_max_ge_min, clock, reset, count_ff != '0, max_ff >= min_ff)
   // A refused push reports a full stack
   `MMS_ASSERT_IMPL(a_full_status, clock, reset,
      rsp_valid_ff && (rsp_status_ff == mms_pkg::ST_FULL),
      rsp_count_ff == CW'(STACK_DEPTH))
   // Empty flag agrees with the reported fill level
   `MMS_ASSERT_IMPL(a_empty_flag, clock, reset, rsp_valid_ff,
      rsp_empty_ff == (rsp_count_ff == '0))
   // A request that fires always yields a result next cycle
   `MMS_ASSERT_NEXT(a_fire_result, clock, reset, fire, rsp_valid_ff)

endmodule
